/* rtl/cstrip_pkg.sv */
// Shared types, character constants and the per-byte decision function of the comment stripper.
package cstrip_pkg;

   localparam logic [7:0] CH_SPACE = 8'h20;
   localparam logic [7:0] CH_CR    = 8'h0D;
   localparam logic [7:0] CH_LF    = 8'h0A;
   localparam logic [7:0] CH_SLASH = 8'h2F;
   localparam logic [7:0] CH_STAR  = 8'h2A;
   localparam logic [7:0] CH_NUL   = 8'h00;

   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

   typedef enum logic [1:0] {
      MODE_OUT   = 2'd0,
      MODE_BLOCK = 2'd1,
      MODE_LINE  = 2'd2
   } mode_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       last_out;
   } entry_type;

   // Up to two results that one accepted input transfer pushes into the queue.
   typedef struct packed {
      logic [1:0] num;
      entry_type  first;
      entry_type  second;
   } push_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       pair;
      mode_type   mode;
   } decision_type;

   // Decides byte c with lookahead n in the given comment mode.
   function automatic decision_type decide(input logic [7:0] c, input logic [7:0] n,
                                           input mode_type mode);
      decision_type d;
      d.out_byte = c;
      d.pair     = 1'b0;
      d.mode     = mode;
      if (c == CH_LF) begin
         if (mode == MODE_LINE) d.mode = MODE_OUT;
      end else if (c == CH_CR) begin
         d.out_byte = CH_NUL;
      end else if (mode == MODE_BLOCK && c == CH_STAR && n == CH_SLASH) begin
         d.mode     = MODE_OUT;
         d.pair     = 1'b1;
         d.out_byte = CH_SPACE;
      end else if (mode != MODE_OUT) begin
         d.out_byte = CH_SPACE;
      end else if (c == CH_SLASH && n == CH_SLASH) begin
         d.mode     = MODE_LINE;
         d.out_byte = CH_SPACE;
      end else if (c == CH_SLASH && n == CH_STAR) begin
         d.mode     = MODE_BLOCK;
         d.pair     = 1'b1;
         d.out_byte = CH_SPACE;
      end
      return d;
   endfunction

endpackage

/* rtl/comment_stripper_unit.sv */
// Top level of the streaming C comment stripper.
//
// This block takes a text stream one byte per transfer and returns the same number of bytes,
// in order. Bytes inside slash-slash and slash-star comments, the markers included, come out
// as spaces; every carriage return comes out as a zero byte; a line feed passes unchanged and
// ends a slash-slash comment. Each byte is decided when the byte after it arrives, so a
// result lags its input by one transfer; req_is_last flushes the held byte and the final byte
// (whose lookahead is taken as zero), and rsp_last_out marks the final result of a text. The
// next text then starts outside any comment. One input transfer is taken per clock while the
// queue is not full: the decision is combinational logic between the lookahead register and
// a four-entry result queue, and a transfer yields zero, one or two results. The queue drains
// one result per clock while the output side does not stall, and input is stalled only while
// fewer than two queue entries are free; each result is registered in the queue before rsp_.
module comment_stripper_unit (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_in_byte,
   input  logic       req_is_last,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [7:0] rsp_out_byte,
   output logic       rsp_last_out
);

   cstrip_pkg::push_type push;
   logic                 queue_full;
   logic                 accept;

   // Input stall follows only the queue fill level, never the input valid.
   assign req_stall = queue_full;
   assign accept    = req_valid && !queue_full;

   cstrip_core u_core (
      .clock   (clock),
      .reset   (reset),
      .accept  (accept),
      .in_byte (req_in_byte),
      .is_last (req_is_last),
      .push    (push)
   );

   cstrip_out_queue u_queue (
      .clock        (clock),
      .reset        (reset),
      .push         (push),
      .full         (queue_full),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_out_byte (rsp_out_byte),
      .rsp_last_out (rsp_last_out)
   );

endmodule

/* rtl/cstrip_core.sv */
// Lookahead register, comment mode register and the decision logic for each input byte.
module cstrip_core (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 accept,
   input  logic [7:0]           in_byte,
   input  logic                 is_last,
   output cstrip_pkg::push_type push
);

   logic [7:0]           held_byte_ff, held_byte_in;
   logic                 held_valid_ff, held_valid_in;
   cstrip_pkg::mode_type mode_ff, mode_in;

   cstrip_pkg::decision_type d_held;
   cstrip_pkg::decision_type d_last;
   cstrip_pkg::mode_type     mode_mid;
   cstrip_pkg::entry_type    last_entry;

   always_comb begin
      d_held   = cstrip_pkg::decide(held_byte_ff, in_byte, mode_ff);
      mode_mid = held_valid_ff ? d_held.mode : mode_ff;
      // The final byte sees a zero lookahead.
      d_last   = cstrip_pkg::decide(in_byte, cstrip_pkg::CH_NUL, mode_mid);
      last_entry.out_byte = d_last.out_byte;
      last_entry.last_out = 1'b1;

      push.num    = 2'd0;
      push.first  = last_entry;
      push.second = last_entry;
      held_byte_in  = held_byte_ff;
      held_valid_in = held_valid_ff;
      mode_in       = mode_ff;

      if (accept) begin
         if (held_valid_ff) begin
            push.first.out_byte = d_held.out_byte;
            push.first.last_out = 1'b0;
            push.num            = 2'd1;
         end
         if (held_valid_ff && d_held.pair) begin
            // The incoming byte completes a two-byte marker and is used up.
            push.second.out_byte = cstrip_pkg::CH_SPACE;
            push.second.last_out = is_last;
            push.num             = 2'd2;
            held_valid_in        = 1'b0;
            held_byte_in         = cstrip_pkg::CH_NUL;
            mode_in              = is_last ? cstrip_pkg::MODE_OUT : d_held.mode;
         end else if (is_last) begin
            push.num      = held_valid_ff ? 2'd2 : 2'd1;
            held_valid_in = 1'b0;
            held_byte_in  = cstrip_pkg::CH_NUL;
            mode_in       = cstrip_pkg::MODE_OUT;
         end else begin
            held_valid_in = 1'b1;
            held_byte_in  = in_byte;
            mode_in       = mode_mid;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         held_byte_ff  <= cstrip_pkg::CH_NUL;
         held_valid_ff <= 1'b0;
         mode_ff       <= cstrip_pkg::MODE_OUT;
      end else begin
         held_byte_ff  <= held_byte_in;
         held_valid_ff <= held_valid_in;
         mode_ff       <= mode_in;
      end
   end

endmodule

/* rtl/cstrip_out_queue.sv */
// Small result queue that takes up to two results per cycle and delivers one per transfer.
module cstrip_out_queue (
   input  logic                 clock,
   input  logic                 reset,
   input  cstrip_pkg::push_type push,
   output logic                 full,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output logic [7:0]           rsp_out_byte,
   output logic                 rsp_last_out
);

   cstrip_pkg::entry_type mem_ff [cstrip_pkg::QUEUE_DEPTH];

   logic [cstrip_pkg::QUEUE_PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [cstrip_pkg::QUEUE_PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [cstrip_pkg::QUEUE_CNT_W-1:0] count_ff, count_in;
   logic [cstrip_pkg::QUEUE_PTR_W-1:0] wr_ptr_next;
   logic                               pop;

   assign rsp_valid    = (count_ff != '0);
   assign pop          = rsp_valid && !rsp_stall;
   // Room for two results is kept so that a stalled head entry is never overwritten.
   assign full         = (count_ff > cstrip_pkg::QUEUE_CNT_W'(cstrip_pkg::QUEUE_DEPTH - 2));
   assign rsp_out_byte = mem_ff[rd_ptr_ff].out_byte;
   assign rsp_last_out = mem_ff[rd_ptr_ff].last_out;
   assign wr_ptr_next  = wr_ptr_ff + 1'b1;

   always_comb begin
      wr_ptr_in = wr_ptr_ff + cstrip_pkg::QUEUE_PTR_W'(push.num);
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff + cstrip_pkg::QUEUE_CNT_W'(push.num)
                  - cstrip_pkg::QUEUE_CNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push.num != 2'd0) mem_ff[wr_ptr_ff] <= push.first;
      if (push.num == 2'd2) mem_ff[wr_ptr_next] <= push.second;
   end

endmodule
